>>> hdl/assert_macros.svh
// assertion macros for the checker file
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define CPG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cpg assertion failed");

// next-cycle implication, disabled while in reset
`define CPG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cpg assertion failed");

`endif

>>> hdl/cpg_pkg.sv
// package for the circle point generator: widths, types, constants
// no dependencies
`timescale 1ns / 1ps

package cpg_pkg;

  localparam int COORD_BITS = 12;
  localparam int DEC_BITS   = COORD_BITS + 4;
  localparam int PT_BITS    = COORD_BITS + 1;
  localparam int RAD_BITS   = COORD_BITS - 1;

  localparam int QDEPTH     = 2;
  localparam int QA_BITS    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QC_BITS    = $clog2(QDEPTH + 1);

  localparam int NPOINTS    = 8;
  localparam int IDX_BITS   = $clog2(NPOINTS);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DEC_BITS-1:0]   dec_t;
  typedef logic signed [PT_BITS-1:0]    pt_t;
  typedef logic [RAD_BITS-1:0]          rad_t;
  typedef logic [IDX_BITS-1:0]          idx_t;

  localparam idx_t LAST_IDX = idx_t'(NPOINTS - 1);

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_e;

  // one iteration handed from front to back
  typedef struct packed {
    coord_t cx;
    coord_t cy;
    coord_t ox;
    coord_t oy;
    logic   done;
  } job_t;

endpackage

>>> hdl/cpg_if.sv
// handshake channels of the circle point generator: command in, point out
// depends on cpg_pkg
`timescale 1ns / 1ps

interface cpg_cmd_if;
  logic             valid;
  logic             ready;
  logic             command;
  cpg_pkg::coord_t  centre_x_in;
  cpg_pkg::coord_t  centre_y_in;
  cpg_pkg::rad_t    radius_in;

  modport source (output valid, command, centre_x_in, centre_y_in, radius_in, input ready);
  modport sink   (input valid, command, centre_x_in, centre_y_in, radius_in, output ready);
endinterface

interface cpg_pt_if;
  logic          valid;
  logic          ready;
  cpg_pkg::pt_t  point_x;
  cpg_pkg::pt_t  point_y;
  logic          octet_last;
  logic          circle_done;

  modport source (output valid, point_x, point_y, octet_last, circle_done, input ready);
  modport sink   (input valid, point_x, point_y, octet_last, circle_done, output ready);
endinterface

>>> hdl/cpg_front.sv
// front part: takes commands, holds circle state, runs one Bresenham iteration per
// start or busy step, pushes its offsets to the queue; depends on cpg_pkg, cpg_if
`timescale 1ns / 1ps

module cpg_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  cpg_cmd_if.sink         cmd_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output cpg_pkg::job_t   push_job_o
);
  import cpg_pkg::*;

  logic   busy_q, busy_d;
  coord_t cx_q, cx_d, cy_q, cy_d;
  coord_t x_q, x_d, y_q, y_d;
  dec_t   d_q, d_d;

  logic   take, start, run, neg, done;
  coord_t cur_x, cur_y, nx, ny, diff;
  dec_t   cur_d, inc;

  assign cmd_i.ready = push_ready_i;
  assign take  = cmd_i.valid && cmd_i.ready;
  assign start = (cmd_i.command == CMD_START);
  assign run   = take && (start || busy_q);

  always_comb begin
    cur_x = start ? '0 : x_q;
    cur_y = start ? coord_t'(cmd_i.radius_in) : y_q;
    cur_d = start ? (dec_t'(3) - (dec_t'(cmd_i.radius_in) <<< 1)) : d_q;
    neg   = cur_d[DEC_BITS-1];
    nx    = cur_x + coord_t'(1);
    diff  = nx - cur_y;
    inc   = neg ? ((dec_t'(nx) <<< 2) + dec_t'(6)) : ((dec_t'(diff) <<< 2) + dec_t'(10));
    ny    = neg ? cur_y : (cur_y - coord_t'(1));
    done  = (nx > ny);
  end

  always_comb begin
    busy_d = busy_q;
    cx_d   = cx_q;
    cy_d   = cy_q;
    x_d    = x_q;
    y_d    = y_q;
    d_d    = d_q;
    if (take && start) begin
      cx_d = cmd_i.centre_x_in;
      cy_d = cmd_i.centre_y_in;
    end
    if (run) begin
      x_d    = nx;
      y_d    = ny;
      d_d    = cur_d + inc;
      busy_d = !done;
    end
  end

  // job carries the offsets before the update
  assign push_valid_o    = run;
  assign push_job_o.cx   = start ? cmd_i.centre_x_in : cx_q;
  assign push_job_o.cy   = start ? cmd_i.centre_y_in : cy_q;
  assign push_job_o.ox   = cur_x;
  assign push_job_o.oy   = cur_y;
  assign push_job_o.done = done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cx_q   <= '0;
      cy_q   <= '0;
      x_q    <= '0;
      y_q    <= '0;
      d_q    <= '0;
    end else begin
      busy_q <= busy_d;
      cx_q   <= cx_d;
      cy_q   <= cy_d;
      x_q    <= x_d;
      y_q    <= y_d;
      d_q    <= d_d;
    end
  end

endmodule

>>> hdl/cpg_queue.sv
// short job queue between front and back
// depends on cpg_pkg
`timescale 1ns / 1ps

module cpg_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  cpg_pkg::job_t   wr_job_i,
  output logic            rd_valid_o,
  input  logic            rd_ready_i,
  output cpg_pkg::job_t   rd_job_o
);
  import cpg_pkg::*;

  job_t                mem_q [QDEPTH];
  logic [QA_BITS-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QC_BITS-1:0]  cnt_q, cnt_d;
  logic                wr_en, rd_en;

  assign wr_ready_o = (cnt_q != QC_BITS'(QDEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_job_o   = mem_q[rd_ptr_q];
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == QA_BITS'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == QA_BITS'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

>>> hdl/cpg_back.sv
// back part: expands one job into eight symmetric points, one per cycle unless the
// output stalls, through a registered output stage; depends on cpg_pkg, cpg_if
`timescale 1ns / 1ps

module cpg_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  output logic            job_ready_o,
  input  cpg_pkg::job_t   job_i,
  cpg_pt_if.source        pt_o
);
  import cpg_pkg::*;

  job_t  job_q, job_d;
  logic  have_q, have_d;
  idx_t  idx_q, idx_d;
  logic  ov_q, ov_d;
  pt_t   px_q, px_d, py_q, py_d;
  logic  last_q, last_d, done_q, done_d;

  logic  load;
  pt_t   ox, oy, dx, dy;

  assign load        = !ov_q || pt_o.ready;
  assign job_ready_o = !have_q || (load && idx_q == LAST_IDX);

  assign ox = pt_t'(job_q.ox);
  assign oy = pt_t'(job_q.oy);

  // symmetric point order
  always_comb begin
    case (idx_q)
      3'd0:    begin dx =  ox; dy =  oy; end
      3'd1:    begin dx =  oy; dy =  ox; end
      3'd2:    begin dx = -ox; dy =  oy; end
      3'd3:    begin dx =  oy; dy = -ox; end
      3'd4:    begin dx = -ox; dy = -oy; end
      3'd5:    begin dx = -oy; dy = -ox; end
      3'd6:    begin dx =  ox; dy = -oy; end
      default: begin dx = -oy; dy =  ox; end
    endcase
  end

  always_comb begin
    job_d  = job_q;
    have_d = have_q;
    idx_d  = idx_q;
    ov_d   = ov_q;
    px_d   = px_q;
    py_d   = py_q;
    last_d = last_q;
    done_d = done_q;
    if (load) begin
      ov_d = have_q;
      if (have_q) begin
        px_d   = pt_t'(job_q.cx) + dx;
        py_d   = pt_t'(job_q.cy) + dy;
        last_d = (idx_q == LAST_IDX);
        done_d = (idx_q == LAST_IDX) && job_q.done;
        idx_d  = idx_q + 1'b1;
      end
    end
    if (job_ready_o) begin
      have_d = job_valid_i;
      job_d  = job_i;
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    px_q   <= px_d;
    py_q   <= py_d;
    last_q <= last_d;
    done_q <= done_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      idx_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      have_q <= have_d;
      idx_q  <= idx_d;
      ov_q   <= ov_d;
    end
  end

  assign pt_o.valid       = ov_q;
  assign pt_o.point_x     = px_q;
  assign pt_o.point_y     = py_q;
  assign pt_o.octet_last  = last_q;
  assign pt_o.circle_done = done_q;

endmodule

>>> hdl/circle_point_generator.sv
// an iteration's points pass the queue, the back's job register and the output register
// throughput: one command per cycle into the front until the queue is full; the back
// emits one point per cycle on the output port unless it stalls, eight per iteration
// a step while idle is taken and gives no points
// reset (async, active low) idles the block; no clearing pass
`timescale 1ns / 1ps

module circle_point_generator (
  input  logic      clk_i,
  input  logic      rst_ni,
  cpg_cmd_if.sink   cmd_i,
  cpg_pt_if.source  pt_o
);
  import cpg_pkg::*;

  // front to queue
  logic  push_valid, push_ready;
  job_t  push_job;

  // queue to back
  logic  pop_valid, pop_ready;
  job_t  pop_job;

  // front: decodes start/step, keeps centre, offsets and decision value,
  // advances the circle once per accepted start, or step while busy
  cpg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  // decouples the front from the back, which emits eight points per job
  cpg_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_job_i   (push_job),
    .rd_valid_o (pop_valid),
    .rd_ready_i (pop_ready),
    .rd_job_o   (pop_job)
  );

  // back: walks the eight symmetric points, next job loads as the last one leaves
  cpg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .job_ready_o (pop_ready),
    .job_i       (pop_job),
    .pt_o        (pt_o)
  );

endmodule

>>> hdl/cpg_checker.sv
// port-level checks for the circle point generator, bound to the top level
// depends on cpg_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cpg_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pt_valid_i,
  input  logic          pt_ready_i,
  input  cpg_pkg::pt_t  pt_point_x_i,
  input  cpg_pkg::pt_t  pt_point_y_i,
  input  logic          pt_octet_last_i,
  input  logic          pt_circle_done_i
);

  // the final point of a circle always closes an octet
  `CPG_ASSERT_NOW(a_done_is_last, pt_valid_i && pt_circle_done_i, pt_octet_last_i)

  // no point shown in the first cycle after reset release
  `CPG_ASSERT_NOW(a_idle_after_reset, $rose(rst_ni), !pt_valid_i)

  // a stalled point stays offered
  `CPG_ASSERT_NEXT(a_stall_valid, pt_valid_i && !pt_ready_i, pt_valid_i)

  // a stalled point keeps its coordinates
  `CPG_ASSERT_NEXT(a_stall_point, pt_valid_i && !pt_ready_i, $stable(pt_point_x_i) && $stable(pt_point_y_i))

endmodule

bind circle_point_generator cpg_checker u_cpg_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .pt_valid_i       (pt_o.valid),
  .pt_ready_i       (pt_o.ready),
  .pt_point_x_i     (pt_o.point_x),
  .pt_point_y_i     (pt_o.point_y),
  .pt_octet_last_i  (pt_o.octet_last),
  .pt_circle_done_i (pt_o.circle_done)
);
